// ===== rtl/core/aes128_block_encrypt_defines.svh =====
// assertion macros for the aes-128 encryption core
// used by the top level only, no other dependencies
`ifndef AES128_BLOCK_ENCRYPT_DEFINES_SVH
`define AES128_BLOCK_ENCRYPT_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication with the consequent checked in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/aes128_pkg.sv =====
// types, s-box table and round helper functions for the aes-128 core
// no dependencies
package aes128_pkg;

	localparam int NUM_ROUNDS = 10;

	typedef logic [127:0] block_t;

	typedef logic [7:0] sbox_table_t [256];

	localparam sbox_table_t SBOX = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	// byte k of a block sits at bits 127-8k : 120-8k
	function automatic logic [7:0] get_byte(block_t b, int k);
		return b[127-8*k -: 8];
	endfunction

	function automatic logic [7:0] xtime(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic block_t sub_shift(block_t s);
		block_t t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
			end
		end
		return t;
	endfunction

	function automatic block_t mix_columns(block_t s);
		block_t t;
		logic [7:0] a0, a1, a2, a3, all;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = get_byte(s, 4*c);
			a1 = get_byte(s, 4*c+1);
			a2 = get_byte(s, 4*c+2);
			a3 = get_byte(s, 4*c+3);
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127-8*(4*c)   -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[127-8*(4*c+1) -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[127-8*(4*c+2) -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[127-8*(4*c+3) -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

	// next round key from the previous one
	function automatic block_t next_key(block_t k, logic [7:0] rc);
		block_t n;
		logic [31:0] w, t;
		w = k[31:0];
		t = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
		n[127:96] = k[127:96] ^ t;
		n[95:64]  = k[95:64]  ^ n[127:96];
		n[63:32]  = k[63:32]  ^ n[95:64];
		n[31:0]   = k[31:0]   ^ n[63:32];
		return n;
	endfunction

endpackage

// ===== rtl/core/aes128_round.sv =====
// one registered aes round: state update and key schedule step
// depends on aes128_pkg
module aes128_round #(
	parameter logic [7:0] RCON = 8'h01,
	parameter bit LAST = 1'b0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  aes128_pkg::block_t in_state,
	input  aes128_pkg::block_t in_key,
	output logic               out_valid,
	output aes128_pkg::block_t out_state,
	output aes128_pkg::block_t out_key
);

	aes128_pkg::block_t key_n, sub_n, mix_n;

	always_comb begin
		key_n = aes128_pkg::next_key(in_key, RCON);
		sub_n = aes128_pkg::sub_shift(in_state);
		mix_n = LAST ? sub_n : aes128_pkg::mix_columns(sub_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_state <= mix_n ^ key_n;
			out_key <= key_n;
		end
	end

endmodule

// ===== rtl/core/aes128_block_encrypt.sv =====
// top level of the pipelined aes-128 encryption core
// depends on aes128_pkg, aes128_round and aes128_block_encrypt_defines.svh
//
// channel  dir  fields (tdata, lowest bit up)
// s_axis   in   key_high, key_low, text_high, text_low (256 bits)
// m_axis   out  cipher_high, cipher_low (128 bits)
//
// one request per cycle while the output does not stall; an initial add-key stage
// plus ten round stages, each one sbox layer and key step
// the whole pipe advances together when the output is free or empty
// reset clears only the valid bits; stalls hold every stage in place
`include "aes128_block_encrypt_defines.svh"
module aes128_block_encrypt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [255:0] s_axis_tdata,  // key_high, key_low, text_high, text_low
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // cipher_high, cipher_low
);

	localparam int N = aes128_pkg::NUM_ROUNDS;
	localparam logic [7:0] RC [10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
		8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

	logic en;
	logic v [N+1];
	aes128_pkg::block_t st [N+1];
	aes128_pkg::block_t ky [N+1];

	// global enable: pipe moves unless the output holds a result not taken
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// stage zero: initial add-key, key bytes in big-endian order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v[0] <= 1'b0;
		end else if (en) begin
			v[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ky[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]};
			st[0] <= {s_axis_tdata[191:128], s_axis_tdata[255:192]}
				^ {s_axis_tdata[63:0], s_axis_tdata[127:64]};
		end
	end

	for (genvar r = 0; r < N; r++) begin : g_round
		aes128_round #(.RCON(RC[r]), .LAST(r == N - 1)) u_round (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v[r]), .in_state(st[r]), .in_key(ky[r]),
			.out_valid(v[r+1]), .out_state(st[r+1]), .out_key(ky[r+1])
		);
	end

	assign m_axis_tvalid = v[N];
	// cipher_high in low bits
	assign m_axis_tdata = {st[N][63:0], st[N][127:64]};

	`ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	`ASSERT_IMPL(a_ready_free, clk, arst_n, !m_axis_tvalid, s_axis_tready)
	`ASSERT_NEXT(a_enter_stage, clk, arst_n, s_axis_tvalid && s_axis_tready, v[0])

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the aes-128 block encryption core
// depends on aes128_pkg (block type) and the aes128_block_encrypt top level
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata;  // key_high, key_low, text_high, text_low
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;  // cipher_high, cipher_low

	aes128_block_encrypt u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	localparam int LATENCY = 11;
	localparam int NUM_RANDOM = 1030;

	typedef struct {
		logic [63:0] key_high, key_low, text_high, text_low;
		logic        known;        // ciphertext typed in below
		logic [63:0] ct_high, ct_low;
	} vector_t;

	// directed rows: fips-197 and sp800-38a known answers, extremes, bit patterns
	vector_t vectors [] = '{
		'{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0011223344556677,
			64'h8899aabbccddeeff, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
		'{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h3243f6a8885a308d,
			64'h313198a2e0370734, 1'b1, 64'h3925841d02dc09fb, 64'hdc118597196a0b32},
		'{64'h0, 64'h0, 64'h0, 64'h0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
		'{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 64'h6bc1bee22e409f96,
			64'he93d7e117393172a, 1'b1, 64'h3ad77bb40d7a3660, 64'ha89ecaf32466ef97},
		'{'1, '1, '1, '1, 1'b0, 64'h0, 64'h0},
		'{'1, '1, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0},
		'{64'h0, 64'h0, '1, '1, 1'b0, 64'h0, 64'h0},
		'{64'h8000000000000000, 64'h0, 64'h0, 64'h1, 1'b0, 64'h0, 64'h0},
		'{64'h0, 64'h1, 64'h8000000000000000, 64'h0, 1'b0, 64'h0, 64'h0},
		'{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 64'h5555555555555555,
			64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0},
		'{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 64'haaaaaaaaaaaaaaaa,
			64'h5555555555555555, 1'b0, 64'h0, 64'h0},
		'{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0, 1'b0, 64'h0, 64'h0}
	};

	logic [127:0] cipher_queue [$];
	int           errors = 0;
	logic         hold_off = 1'b0;
	logic         sender_done = 1'b0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// gap length: mostly short, sometimes long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// predictor: byte 0 of a block is its top byte
	function automatic logic [7:0] gmul2(logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[0]) acc ^= a;
			a = gmul2(a);
			b = b >> 1;
		end
		return acc;
	endfunction

	// s-box computed from the field inverse and the affine map, not a table
	function automatic logic [7:0] sbox_of(logic [7:0] x);
		logic [7:0] sq, acc, p, b;
		sq = gmul(x, x);
		acc = sq;
		p = sq;
		for (int k = 0; k < 6; k++) begin
			p = gmul(p, p);
			acc = gmul(acc, p);
		end
		b = acc;
		return b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
			^ {b[3:0], b[7:4]} ^ 8'h63;
	endfunction

	// req holds key_high, key_low, text_high, text_low from the top down
	function automatic logic [127:0] encrypt_block(logic [255:0] req);
		logic [7:0] w [176];
		logic [7:0] st [16];
		logic [7:0] tmp [16];
		logic [7:0] t0, t1, t2, t3, f, rc, a0, a1, a2, a3, all;
		logic [127:0] out;
		for (int k = 0; k < 16; k++) begin
			w[k] = req[255-8*k -: 8];
			st[k] = req[127-8*k -: 8];
		end
		rc = 8'h01;
		for (int i = 16; i < 176; i += 4) begin
			t0 = w[i-4]; t1 = w[i-3]; t2 = w[i-2]; t3 = w[i-1];
			if (i % 16 == 0) begin
				f = t0;
				t0 = sbox_of(t1) ^ rc;
				t1 = sbox_of(t2);
				t2 = sbox_of(t3);
				t3 = sbox_of(f);
				rc = gmul2(rc);
			end
			w[i] = w[i-16] ^ t0;
			w[i+1] = w[i-15] ^ t1;
			w[i+2] = w[i-14] ^ t2;
			w[i+3] = w[i-13] ^ t3;
		end
		for (int k = 0; k < 16; k++) st[k] ^= w[k];
		for (int rnd = 1; rnd <= 10; rnd++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					tmp[4*c+r] = sbox_of(st[4*((c+r)%4)+r]);
			st = tmp;
			if (rnd < 10) begin
				for (int c = 0; c < 4; c++) begin
					a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					st[4*c] = a0 ^ all ^ gmul2(a0 ^ a1);
					st[4*c+1] = a1 ^ all ^ gmul2(a1 ^ a2);
					st[4*c+2] = a2 ^ all ^ gmul2(a2 ^ a3);
					st[4*c+3] = a3 ^ all ^ gmul2(a3 ^ a0);
				end
			end
			for (int k = 0; k < 16; k++) st[k] ^= w[16*rnd+k];
		end
		for (int k = 0; k < 16; k++) out[127-8*k -: 8] = st[k];
		return out;
	endfunction

	// offer one request, hold it until accepted, then queue its ciphertext
	// tdata carries key_high in its lowest 64 bits
	task automatic send_request(logic [255:0] req, logic [127:0] ciphertext);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {req[63:0], req[127:64], req[191:128], req[255:192]};
		do @(posedge clk); while (!s_axis_tready);
		cipher_queue.push_back(ciphertext);
	endtask

	task automatic idle_sender(int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= {$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom};
			repeat (n) @(posedge clk);
		end
	endtask

	// sender
	initial begin
		aes128_pkg::block_t expected;
		logic [255:0] req;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, back to back
		foreach (vectors[i]) begin
			req = {vectors[i].key_high, vectors[i].key_low,
				vectors[i].text_high, vectors[i].text_low};
			expected = vectors[i].known ? {vectors[i].ct_high, vectors[i].ct_low}
				: encrypt_block(req);
			send_request(req, expected);
		end

		for (int n = 0; n < NUM_RANDOM; n++) begin
			// pause until the pipe drains
			if (n == 300) begin
				s_axis_tvalid <= 1'b0;
				while (cipher_queue.size() != 0) @(posedge clk);
			end
			// keep offering while the receiver holds off
			if (n == 500) hold_off <= 1'b1;
			if (n >= 200 && n < 260) begin
				// only one key bit or text bit set, or on odd n only one clear
				req = 256'h1 << $urandom_range(0, 255);
				if (n % 2) req = ~req;
			end else begin
				req = {$urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom};
			end
			send_request(req, encrypt_block(req));
			if (n < 100 || (n >= 500 && n < 600)) idle_sender(0);
			else idle_sender(gap_len());
		end
		s_axis_tvalid <= 1'b0;
		sender_done <= 1'b1;
	end

	// receiver ready pattern; one long hold-off when asked
	initial begin
		bit held;
		held = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off && !held) begin
				m_axis_tready <= 1'b0;
				repeat (80) @(posedge clk);
				held = 1'b1;
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			if (gap_len() > 0 && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap_len() + 1) @(posedge clk);
			end
		end
	end

	// checker on every accepted result, cipher_high in the low tdata bits
	always @(posedge clk) begin
		logic [127:0] expected_ct;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (cipher_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, m_axis_tdata);
				errors++;
			end else begin
				expected_ct = cipher_queue.pop_front();
				if (m_axis_tdata[63:0] !== expected_ct[127:64]) begin
					$display("%0t: cipher_high expected %h actual %h", $realtime,
						expected_ct[127:64], m_axis_tdata[63:0]);
					errors++;
				end
				if (m_axis_tdata[127:64] !== expected_ct[63:0]) begin
					$display("%0t: cipher_low expected %h actual %h", $realtime,
						expected_ct[63:0], m_axis_tdata[127:64]);
					errors++;
				end
			end
		end
	end

	// end of run
	initial begin
		wait (sender_done);
		while (cipher_queue.size() != 0) @(posedge clk);
		repeat (LATENCY * 3) @(posedge clk);
		if (errors == 0 && cipher_queue.size() == 0)
			$display("aes128_block_encrypt: match");
		else
			$display("aes128_block_encrypt: mismatch");
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("aes128_block_encrypt: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/aes128_pkg.sv
rtl/core/aes128_round.sv
rtl/core/aes128_block_encrypt.sv
verif/testbench.sv
